// ===== hw/rtl/cdma_multiuser_spreader_unit_defines.svh =====
// Assertion macros used by the spreader top module.
`ifndef CDMA_MULTIUSER_SPREADER_UNIT_DEFINES_SVH
`define CDMA_MULTIUSER_SPREADER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CDMA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cdma_pkg.sv =====
`default_nettype none

package cdma_pkg;

  // Sizing of the block
  localparam int USERS = 8;
  localparam int CHIPS = 16;

  // Field layout of the code registers: 16 chip bits per user, 4 users per word
  localparam int CODE_W         = 16;
  localparam int USERS_PER_WORD = 4;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;

  // Payload widths
  localparam int USER_BITS_W = 8;
  localparam int CHIP_VAL_W  = 5;
  localparam int CHIP_IDX_W  = 4;

  // Internal widths
  localparam int USER_CNT_W = $clog2(USERS + 1);
  localparam int USER_IDX_W = $clog2(USERS);
  localparam int CHIP_CNT_W = $clog2(CHIPS + 1);
  localparam int POP_W      = $clog2(CODE_W + 1);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USER_COUNT = 3'd0,
    CFG_CHIP_COUNT = 3'd1,
    CFG_CODES_LOW  = 3'd2,
    CFG_CODES_HIGH = 3'd3
  } cfg_reg_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CHECK,
    ST_IDLE,
    ST_RUN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic sweep_load;
    logic sweep_step;
    logic load_first;
    logic next_chip;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic out_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cdma_multiuser_spreader_unit.sv =====
// Multi-user direct-sequence spreader.
// Input channel (in_valid/in_stall): one symbol time, a data bit and an
// active flag per user plus final_symbol. Output channel (out_valid/out_stall):
// one transaction per chip with chip_value, chip_index, last_chip,
// codes_valid and final_symbol_res; last_chip marks the end of the run.
// Config channel (cfg_valid/cfg_ready): register index and 64-bit data,
// cfg_ready is always high; writes must be made only while the block is
// idle, which the block does not enforce. Latency: chip 0 is on the output
// the cycle after the symbol is accepted. Throughput: one chip per cycle
// while the receiver does not stall; the next symbol is accepted in the
// cycle its predecessor's last chip is taken. When the used codes are not
// pairwise orthogonal, a symbol gives a single transaction, codes_valid low.
// After reset and after every config write, the code check runs with
// in_stall high: one load of the shift line, then sweep steps that shift
// the codes through the comparators.
// Reset clears the controller and restores the register defaults. While the
// receiver stalls, the current chip holds on the outputs and no new symbol
// is taken once the last chip is waiting.
`default_nettype none

`include "cdma_multiuser_spreader_unit_defines.svh"

module cdma_multiuser_spreader_unit import cdma_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [USER_BITS_W-1:0]       data_bits,
  input  logic [USER_BITS_W-1:0]       active_mask,
  input  logic                         final_symbol,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [CHIP_VAL_W-1:0] chip_value,
  output logic [CHIP_IDX_W-1:0]        chip_index,
  output logic                         last_chip,
  output logic                         codes_valid,
  output logic                         final_symbol_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  cdma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  cdma_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .data_bits        (data_bits),
    .active_mask      (active_mask),
    .final_symbol     (final_symbol),
    .chip_value       (chip_value),
    .chip_index       (chip_index),
    .last_chip        (last_chip),
    .codes_valid      (codes_valid),
    .final_symbol_res (final_symbol_res)
  );

  // Chips of one run come out in order, back to back
  `CDMA_ASSERT_NEXT(a_chip_advance, clk, rst,
    out_valid && !out_stall && !last_chip,
    out_valid && (chip_index == $past(chip_index) + 4'd1),
    "chip run did not advance by one")

  // An accepted symbol starts its run at chip zero
  `CDMA_ASSERT_NEXT(a_run_start, clk, rst,
    in_valid && !in_stall,
    out_valid && (chip_index == 4'd0),
    "accepted symbol did not start at chip zero")

  // A failed code check gives a lone, final transaction
  `CDMA_ASSERT_NOW(a_bad_codes_single, clk, rst,
    out_valid && !codes_valid,
    last_chip && (chip_index == 4'd0) && (chip_value == 5'sd0),
    "flagged result is not a single empty transaction")

  // A new symbol enters a busy block only as the last chip leaves
  `CDMA_ASSERT_NOW(a_overlap_only_at_end, clk, rst,
    in_valid && !in_stall && out_valid,
    !out_stall && last_chip,
    "symbol accepted while a run was still in progress")

endmodule

`default_nettype wire

// ===== hw/rtl/cdma_ctrl.sv =====
`default_nettype none

module cdma_ctrl import cdma_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  logic   out_stall,
  input  logic   cfg_we,
  input  stat_t  stat,
  output cmd_t   cmd,
  output logic   in_stall,
  output logic   out_valid
);

  state_t state;
  state_t state_next;
  logic   out_take;
  logic   in_take;

  assign out_take = (state == ST_RUN) && !out_stall;
  assign in_take  = in_valid && !in_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    if (cfg_we) begin
      state_next = ST_LOAD;
    end else begin
      unique case (state)
        ST_LOAD:  state_next = ST_CHECK;
        ST_CHECK: if (stat.sweep_last) state_next = ST_IDLE;
        ST_IDLE:  if (in_valid) state_next = ST_RUN;
        ST_RUN: begin
          if (out_take && stat.out_last && !in_valid) state_next = ST_IDLE;
        end
        default:  state_next = ST_LOAD;
      endcase
    end
  end

  // Outputs: a new symbol may enter as the last chip of the previous one leaves
  always_comb begin
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    cmd.sweep_load = 1'b0;
    cmd.sweep_step = 1'b0;
    cmd.next_chip  = 1'b0;
    unique case (state)
      ST_LOAD:  cmd.sweep_load = 1'b1;
      ST_CHECK: cmd.sweep_step = 1'b1;
      ST_IDLE:  in_stall = 1'b0;
      ST_RUN: begin
        out_valid     = 1'b1;
        in_stall      = !(out_take && stat.out_last);
        cmd.next_chip = out_take && !stat.out_last;
      end
      default: ;
    endcase
    cmd.load_first = in_take;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cdma_dp.sv =====
`default_nettype none

module cdma_dp import cdma_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic [USER_BITS_W-1:0]       data_bits,
  input  logic [USER_BITS_W-1:0]       active_mask,
  input  logic                         final_symbol,
  output logic signed [CHIP_VAL_W-1:0] chip_value,
  output logic [CHIP_IDX_W-1:0]        chip_index,
  output logic                         last_chip,
  output logic                         codes_valid,
  output logic                         final_symbol_res
);

  // Configuration, held saturated
  logic [USER_CNT_W-1:0] user_used;
  logic [CHIP_CNT_W-1:0] chip_used;
  logic [CFG_DATA_W-1:0] codes_low;
  logic [CFG_DATA_W-1:0] codes_high;

  // Orthogonality sweep
  logic [CODE_W-1:0]     code_of [USERS];
  logic [CODE_W-1:0]     sh [USERS];
  logic [USER_IDX_W-1:0] sweep_idx;
  logic                  check_ok;
  logic [CODE_W-1:0]     chip_mask;
  logic                  pair_bad;

  // Symbol being spread
  logic [USER_BITS_W-1:0]       data_r;
  logic [USER_BITS_W-1:0]       mask_r;
  logic [USER_BITS_W-1:0]       src_data;
  logic [USER_BITS_W-1:0]       src_mask;
  logic [CHIP_IDX_W-1:0]        jsel;
  logic signed [CHIP_VAL_W-1:0] sum;
  logic                         last_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      user_used  <= USER_CNT_W'(USERS);
      chip_used  <= CHIP_CNT_W'(CHIPS);
      codes_low  <= '0;
      codes_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_USER_COUNT: begin
          user_used <= (32'(cfg_data[3:0]) > 32'(USERS)) ? USER_CNT_W'(USERS)
                                                          : USER_CNT_W'(cfg_data[3:0]);
        end
        CFG_CHIP_COUNT: begin
          if (cfg_data[4:0] == 5'd0) begin
            chip_used <= CHIP_CNT_W'(1);
          end else if (32'(cfg_data[4:0]) > 32'(CHIPS)) begin
            chip_used <= CHIP_CNT_W'(CHIPS);
          end else begin
            chip_used <= CHIP_CNT_W'(cfg_data[4:0]);
          end
        end
        CFG_CODES_LOW:  codes_low  <= cfg_data;
        CFG_CODES_HIGH: codes_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-user code slices
  always_comb begin
    for (int u = 0; u < USERS; u++) begin
      if (u < USERS_PER_WORD) begin
        code_of[u] = codes_low[(u % USERS_PER_WORD)*CODE_W +: CODE_W];
      end else begin
        code_of[u] = codes_high[(u % USERS_PER_WORD)*CODE_W +: CODE_W];
      end
    end
  end

  // Chips that take part in the dot products
  always_comb begin
    for (int j = 0; j < CODE_W; j++) begin
      chip_mask[j] = (32'(j) < 32'(chip_used));
    end
  end

  // Head of the shift line against every later entry; a pair is zero when
  // agreements make up exactly half of the used chips
  always_comb begin
    logic [POP_W-1:0]      pop;
    logic [USER_CNT_W:0]   pos;
    pair_bad = 1'b0;
    for (int k = 1; k < USERS; k++) begin
      pos = (USER_CNT_W+1)'(sweep_idx) + (USER_CNT_W+1)'(k);
      pop = POP_W'($countones(~(sh[0] ^ sh[k]) & chip_mask));
      if ((pos < (USER_CNT_W+1)'(user_used)) &&
          ({1'b0, pop, 1'b0} != (POP_W+2)'(chip_used))) begin
        pair_bad = 1'b1;
      end
    end
  end

  // Sweep registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
      check_ok  <= 1'b1;
    end else if (cmd.sweep_load) begin
      sweep_idx <= '0;
      check_ok  <= 1'b1;
    end else if (cmd.sweep_step) begin
      sweep_idx <= sweep_idx + USER_IDX_W'(1);
      check_ok  <= check_ok & ~pair_bad;
    end
  end

  // Code shift line
  always_ff @(posedge clk) begin
    if (cmd.sweep_load) begin
      for (int u = 0; u < USERS; u++) begin
        sh[u] <= code_of[u];
      end
    end else if (cmd.sweep_step) begin
      for (int u = 0; u < USERS - 1; u++) begin
        sh[u] <= sh[u+1];
      end
    end
  end

  assign stat.sweep_last = (sweep_idx == USER_IDX_W'(USERS - 2));
  assign stat.out_last   = last_chip;

  // Chip sum: incoming symbol for chip zero, held symbol afterwards
  assign src_data  = cmd.load_first ? data_bits   : data_r;
  assign src_mask  = cmd.load_first ? active_mask : mask_r;
  assign jsel      = cmd.load_first ? '0 : chip_index + CHIP_IDX_W'(1);
  assign last_next = ((CHIP_CNT_W'(jsel) + CHIP_CNT_W'(1)) == chip_used);

  always_comb begin
    sum = '0;
    for (int u = 0; u < USERS; u++) begin
      if ((32'(u) < 32'(user_used)) && src_mask[u]) begin
        sum = sum + ((src_data[u] == code_of[u][jsel]) ? 5'sd1 : -5'sd1);
      end
    end
  end

  // Held symbol and output register
  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      data_r           <= data_bits;
      mask_r           <= active_mask;
      final_symbol_res <= final_symbol;
      chip_index       <= '0;
      codes_valid      <= check_ok;
      if (check_ok) begin
        chip_value <= sum;
        last_chip  <= last_next;
      end else begin
        chip_value <= '0;
        last_chip  <= 1'b1;
      end
    end else if (cmd.next_chip) begin
      chip_value <= sum;
      chip_index <= jsel;
      last_chip  <= last_next;
    end
  end

endmodule

`default_nettype wire
